/* sv/cbp_pkg.sv */
// ----------------------------------------------------------------------------
// cbp_pkg
// Types and constants shared by the CRC codeword bit packer.
// ----------------------------------------------------------------------------
package cbp_pkg;

	localparam int MAX_GEN_BITS = 9;
	localparam int POLY_W       = 9;
	localparam int GEN_W        = (MAX_GEN_BITS < POLY_W) ? MAX_GEN_BITS : POLY_W;
	localparam int BYTE_W       = 8;
	localparam int NIB_W        = 4;
	localparam int COUNT_W      = 16;
	localparam int REM_W        = BYTE_W + GEN_W - 1;
	localparam int NIB_CW_W     = NIB_W + GEN_W - 1;
	localparam int WORD_W       = (2 * NIB_CW_W > REM_W) ? 2 * NIB_CW_W : REM_W;
	localparam int NBITS_W      = $clog2(WORD_W + 1);
	localparam int ACC_W        = WORD_W + BYTE_W - 1;
	localparam int TOT_W        = $clog2(ACC_W + 1);
	localparam int GSZ_W        = $clog2(GEN_W + 1);
	localparam int CSZ_W        = $clog2(REM_W + 1);
	localparam int PAD_W        = $clog2(BYTE_W + 1);
	localparam int ADDR_W       = 3;
	localparam int APB_DATA_W   = 32;

	localparam logic              MODE_RST = 1'b1;
	localparam logic [POLY_W-1:0] POLY_RST = POLY_W'(11);

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_DATA  = 1'b1
	} cbp_cmd_t;

	typedef enum logic {
		REG_MODE = 1'b0,
		REG_POLY = 1'b1
	} cbp_reg_t;

	typedef struct packed {
		logic              dataword_mode;
		logic [POLY_W-1:0] generator_poly;
	} cbp_cfg_t;

	typedef struct packed {
		logic               is_start;
		logic [WORD_W-1:0]  word;
		logic [NBITS_W-1:0] nbits;
	} cbp_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} cbp_qstat_t;

endpackage

/* sv/cbp_intf.sv */
// ----------------------------------------------------------------------------
// cbp_intf
// Valid/ready channels for input items and packed result bytes.
// ----------------------------------------------------------------------------
interface cbp_item_if
	import cbp_pkg::*;
();
	logic               valid;
	logic               ready;
	logic               cmd;
	logic [BYTE_W-1:0]  data_byte;
	logic [COUNT_W-1:0] char_count;

	modport source (output valid, cmd, data_byte, char_count, input ready);
	modport sink (input valid, cmd, data_byte, char_count, output ready);
	modport monitor (input valid, ready, cmd, data_byte, char_count);
endinterface

interface cbp_result_if
	import cbp_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              last;

	modport source (output valid, out_byte, last, input ready);
	modport sink (input valid, out_byte, last, output ready);
	modport monitor (input valid, ready, out_byte, last);
endinterface

/* sv/cbp_front.sv */
// ----------------------------------------------------------------------------
// cbp_front
// Accepts items, encodes datawords into codewords or works out the padding
// count of a start item, and pushes one packing entry per item.
// ----------------------------------------------------------------------------
module cbp_front
	import cbp_pkg::*;
(
	input  cbp_cfg_t   cfg,
	cbp_item_if.sink   item,
	input  cbp_qstat_t qstat,
	output logic       push,
	output cbp_entry_t entry
);

	localparam int IDX_W = $clog2(REM_W);

	function automatic logic [GSZ_W-1:0] gen_size(input logic [GEN_W-1:0] gen);
		logic [GSZ_W-1:0] n;
		n = GSZ_W'(1);
		for (int i = 0; i < GEN_W; i++) begin
			if (gen[i]) begin
				n = GSZ_W'(i + 1);
			end
		end
		return n;
	endfunction

	function automatic logic [REM_W-1:0] encode_word(
		input logic [BYTE_W-1:0] d,
		input logic [GEN_W-1:0]  gen,
		input logic [GSZ_W-1:0]  g
	);
		logic [REM_W-1:0] dext;
		logic [REM_W-1:0] rem;
		logic [REM_W-1:0] gext;
		logic [IDX_W-1:0] idx;
		dext = REM_W'(d) << (g - GSZ_W'(1));
		rem  = dext;
		gext = (gen == '0) ? REM_W'(1) : REM_W'(gen);
		for (int k = BYTE_W - 1; k >= 0; k--) begin
			idx = IDX_W'(k) + IDX_W'(g) - IDX_W'(1);
			if (rem[idx]) begin
				rem = rem ^ (gext << k);
			end
		end
		return dext | rem;
	endfunction

	logic [GEN_W-1:0]  gen;
	logic [GSZ_W-1:0]  g;
	logic [CSZ_W-1:0]  csz;
	logic [BYTE_W-1:0] da;
	logic [BYTE_W-1:0] db;
	logic [REM_W-1:0]  cw_a;
	logic [REM_W-1:0]  cw_b;
	logic [2:0]        prod;
	logic [2:0]        low3;
	logic [PAD_W-1:0]  pad;

	assign gen  = cfg.generator_poly[GEN_W-1:0];
	assign g    = gen_size(gen);
	assign csz  = (cfg.dataword_mode ? CSZ_W'(BYTE_W) : CSZ_W'(NIB_W)) + CSZ_W'(g)
		- CSZ_W'(1);
	assign da   = cfg.dataword_mode ? item.data_byte
		: BYTE_W'(item.data_byte[BYTE_W-1:NIB_W]);
	assign db   = BYTE_W'(item.data_byte[NIB_W-1:0]);
	assign cw_a = encode_word(da, gen, g);
	assign cw_b = encode_word(db, gen, g);
	assign prod = csz[2:0] * item.char_count[2:0];
	assign low3 = cfg.dataword_mode ? prod : {prod[1:0], 1'b0};
	assign pad  = PAD_W'(BYTE_W) - PAD_W'(low3);

	assign item.ready = !qstat.full;
	assign push       = item.valid && !qstat.full;

	always_comb begin
		unique case (cbp_cmd_t'(item.cmd))
			CMD_START: begin
				entry.is_start = 1'b1;
				entry.word     = '0;
				entry.nbits    = NBITS_W'(pad);
			end
			CMD_DATA: begin
				entry.is_start = 1'b0;
				if (cfg.dataword_mode) begin
					entry.word  = WORD_W'(cw_a);
					entry.nbits = NBITS_W'(csz);
				end else begin
					entry.word  = (WORD_W'(cw_a) << csz) | WORD_W'(cw_b);
					entry.nbits = NBITS_W'({csz, 1'b0});
				end
			end
			default: begin
				entry.is_start = 1'b0;
				entry.word     = '0;
				entry.nbits    = '0;
			end
		endcase
	end

endmodule

/* sv/cbp_queue.sv */
// ----------------------------------------------------------------------------
// cbp_queue
// Short first-in first-out queue of packing entries between front and back.
// ----------------------------------------------------------------------------
module cbp_queue
	import cbp_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  cbp_entry_t wr_entry,
	input  logic       pop,
	output cbp_entry_t head,
	output cbp_qstat_t qstat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cbp_entry_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign qstat.full  = (count_q == CNT_W'(DEPTH));
	assign qstat.empty = (count_q == '0);
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign head        = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* sv/cbp_back.sv */
// ----------------------------------------------------------------------------
// cbp_back
// Bit packer: merges entries behind pending bits and emits one byte per
// cycle while the result side is ready, MSB first, through an output register.
// ----------------------------------------------------------------------------
module cbp_back
	import cbp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cbp_entry_t  head,
	input  cbp_qstat_t  qstat,
	output logic        pop,
	cbp_result_if.source result
);

	logic [ACC_W-1:0]  buf_q;
	logic [TOT_W-1:0]  tot_q;
	logic              padp_q;
	logic [PAD_W-1:0]  pad_q;
	logic              ov_q;
	logic [BYTE_W-1:0] ob_q;
	logic              olast_q;

	logic              slot_free;
	logic              emit;
	logic [BYTE_W-1:0] byte_d;
	logic              last_d;
	logic [TOT_W-1:0]  tot_a;
	logic              padp_a;
	logic              drained;
	logic [ACC_W-1:0]  sh;

	assign slot_free = !ov_q || result.ready;
	assign emit      = slot_free && (padp_q || tot_q >= TOT_W'(BYTE_W));
	assign sh        = buf_q >> (tot_q - TOT_W'(BYTE_W));

	always_comb begin
		byte_d = sh[BYTE_W-1:0];
		last_d = 1'b0;
		tot_a  = tot_q;
		padp_a = padp_q;
		priority if (emit && padp_q) begin
			byte_d = BYTE_W'(pad_q);
			padp_a = 1'b0;
			last_d = (tot_q < TOT_W'(BYTE_W));
		end else if (emit) begin
			tot_a  = tot_q - TOT_W'(BYTE_W);
			last_d = (tot_a < TOT_W'(BYTE_W));
		end
	end

	assign drained = !padp_a && (tot_a < TOT_W'(BYTE_W));
	assign pop     = drained && !qstat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q  <= '0;
			tot_q  <= '0;
			padp_q <= 1'b0;
			pad_q  <= '0;
		end else if (pop) begin
			buf_q  <= (buf_q << head.nbits) | ACC_W'(head.word);
			tot_q  <= tot_a + TOT_W'(head.nbits);
			padp_q <= head.is_start;
			pad_q  <= head.nbits[PAD_W-1:0];
		end else begin
			tot_q  <= tot_a;
			padp_q <= padp_a;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (emit) begin
			ov_q <= 1'b1;
		end else if (result.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			ob_q    <= byte_d;
			olast_q <= last_d;
		end
	end

	assign result.valid    = ov_q;
	assign result.out_byte = ob_q;
	assign result.last     = olast_q;

endmodule

/* sv/crc_codeword_bit_packer_top.sv */
// ----------------------------------------------------------------------------
// crc_codeword_bit_packer_top
// Systematic CRC encoder with MSB-first bit packing and APB configuration.
// ----------------------------------------------------------------------------
// Channel   Role    Carries
// item      sink    cmd, data_byte, char_count
// result    source  out_byte, last
// APB       slave   dataword_mode at 0x0, generator_poly at 0x4
//
// A data item yields at least one and at most three output bytes; a start
// item yields one or two. The packer sends them through a single output
// register, one byte per cycle while the result side is ready.
// Reset clears pending bits, the queue and the output valid flag.
// Items are taken while the queue has room, whatever the result side does.
// ----------------------------------------------------------------------------
module crc_codeword_bit_packer_top
	import cbp_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	cbp_item_if.sink              item,
	cbp_result_if.source          result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_W-1:0]     paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic              mode_q;
	logic [POLY_W-1:0] poly_q;
	cbp_cfg_t          cfg;
	cbp_reg_t          reg_sel;
	logic              wr_en;
	logic              push;
	logic              pop;
	cbp_entry_t        wr_entry;
	cbp_entry_t        head;
	cbp_qstat_t        qstat;

	assign pready  = 1'b1;
	assign reg_sel = cbp_reg_t'(paddr[ADDR_W-1:2]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RST;
			poly_q <= POLY_RST;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_MODE: mode_q <= pwdata[0];
				REG_POLY: poly_q <= pwdata[POLY_W-1:0];
				default:  mode_q <= mode_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_MODE: prdata = APB_DATA_W'(mode_q);
			REG_POLY: prdata = APB_DATA_W'(poly_q);
			default:  prdata = '0;
		endcase
	end

	assign cfg.dataword_mode  = mode_q;
	assign cfg.generator_poly = poly_q;

	cbp_front u_front (
		.cfg   (cfg),
		.item  (item),
		.qstat (qstat),
		.push  (push),
		.entry (wr_entry)
	);

	cbp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat)
	);

	cbp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.result (result)
	);

endmodule

/* sv/cbp_checker.sv */
// ----------------------------------------------------------------------------
// cbp_checker
// Port-level checks on the CRC codeword bit packer, bound to the top level.
// ----------------------------------------------------------------------------
module cbp_checker
	import cbp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_ready,
	input  logic                  result_valid,
	input  logic                  result_ready,
	input  logic [BYTE_W-1:0]     out_byte,
	input  logic                  last,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_W-1:0]     paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	input  logic [APB_DATA_W-1:0] prdata
);

	a_quiet_in_reset: assert property (@(posedge clk)
		!arst_n |-> !result_valid)
		else $error("result valid during reset");

	a_ready_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> item_ready)
		else $error("item not taken right after reset");

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped while stalled");

	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(out_byte) && $stable(last))
		else $error("result payload changed while stalled");

	a_poly_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && paddr == ADDR_W'(4)) ##1 (paddr == ADDR_W'(4))
		|-> prdata[POLY_W-1:0] == $past(pwdata[POLY_W-1:0]))
		else $error("generator register readback mismatch");

endmodule

bind crc_codeword_bit_packer_top cbp_checker u_cbp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_ready   (item.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.out_byte     (result.out_byte),
	.last         (result.last),
	.psel         (psel),
	.penable      (penable),
	.pwrite       (pwrite),
	.paddr        (paddr),
	.pwdata       (pwdata),
	.prdata       (prdata)
);
